// ----- design/rle4sps_pkg.sv -----
// Package for the RLE4 stream pad stripper.
// Holds the escape codes and the entry type passed from front to back.
// No dependencies.
package rle4sps_pkg;

    localparam logic [7:0] ESC_MARK  = 8'h00;
    localparam logic [7:0] ESC_EOL   = 8'h00;
    localparam logic [7:0] ESC_EOB   = 8'h01;
    localparam logic [7:0] ESC_DELTA = 8'h02;
    localparam logic [7:0] PAD_FILL  = 8'h00;

    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);

    // One entry: up to three bytes to emit; eoi marks the last of them.
    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       eoi;
    } entry_t;

endpackage

// ----- design/rle4sps_front.sv -----
// Front end: accepts input bytes, tracks the RLE4 parse and builds entries.
// Depends on rle4sps_pkg.
module rle4sps_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                last_of_array,
    output logic                ent_valid,
    output rle4sps_pkg::entry_t ent
);
    import rle4sps_pkg::*;

    typedef enum logic [2:0] {
        PH_FIRST  = 3'd0,
        PH_SECOND = 3'd1,
        PH_COPY   = 3'd2,
        PH_PAD    = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;
    logic [6:0] left_reg, left_next;
    logic       pad_reg, pad_next;
    logic       parity_reg, parity_next;
    logic [7:0] cnt8;
    entry_t     e;

    always_comb
    begin
        phase_next  = phase_reg;
        held_next   = held_reg;
        left_next   = left_reg;
        pad_next    = pad_reg;
        e           = '0;
        cnt8        = {1'b0, data_byte[7:1]} + {7'd0, data_byte[0]};
        unique case (phase_reg)
            PH_SECOND:
            begin
                e.b0 = held_reg;
                e.b1 = data_byte;
                e.cnt = 2'd2;
                phase_next = PH_FIRST;
                if (held_reg == ESC_MARK)
                begin
                    if (data_byte == ESC_EOL)
                    begin
                        phase_next = PH_FIRST;
                    end
                    else if (data_byte == ESC_EOB)
                    begin
                        // Two more bytes keep parity; pad if already odd.
                        e.eoi = 1'b1;
                        e.b2  = PAD_FILL;
                        e.cnt = parity_reg ? 2'd3 : 2'd2;
                        phase_next = PH_DONE;
                    end
                    else if (data_byte == ESC_DELTA)
                    begin
                        left_next  = 7'd1;
                        pad_next   = 1'b0;
                        phase_next = PH_COPY;
                    end
                    else
                    begin
                        left_next  = cnt8[6:0] - 7'd1;
                        pad_next   = cnt8[0];
                        phase_next = PH_COPY;
                    end
                end
            end
            PH_COPY:
            begin
                e.b0  = data_byte;
                e.cnt = 2'd1;
                if (left_reg == 7'd0)
                begin
                    phase_next = pad_reg ? PH_PAD : PH_FIRST;
                end
                else
                begin
                    left_next = left_reg - 7'd1;
                end
            end
            PH_PAD:
            begin
                // Drop the pad byte whatever its value.
                pad_next   = 1'b0;
                phase_next = PH_FIRST;
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                held_next  = data_byte;
                phase_next = PH_SECOND;
            end
        endcase
        parity_next = parity_reg ^ e.cnt[0];
        if (last_of_array)
        begin
            phase_next  = PH_FIRST;
            held_next   = 8'd0;
            left_next   = 7'd0;
            pad_next    = 1'b0;
            parity_next = 1'b0;
        end
    end

    assign ent       = e;
    assign ent_valid = accept && (e.cnt != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FIRST;
            held_reg   <= 8'd0;
            left_reg   <= 7'd0;
            pad_reg    <= 1'b0;
            parity_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            held_reg   <= held_next;
            left_reg   <= left_next;
            pad_reg    <= pad_next;
            parity_reg <= parity_next;
        end
    end

endmodule

// ----- design/rle4sps_queue.sv -----
// Short entry queue between the front and back ends.
// Depends on rle4sps_pkg.
module rle4sps_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  rle4sps_pkg::entry_t wr_data,
    output logic                full,
    input  logic                rd_en,
    output rle4sps_pkg::entry_t rd_data,
    output logic                empty
);
    import rle4sps_pkg::*;

    entry_t         mem_reg [QDepth];
    logic [QAw-1:0] wptr_reg, rptr_reg;
    logic [QAw:0]   count_reg, count_next;
    logic           do_wr, do_rd;

    assign full    = (count_reg == (QAw+1)'(QDepth));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ----- design/rle4sps_back.sv -----
// Back end: expands queued entries into single bytes in an output register.
// Depends on rle4sps_pkg.
module rle4sps_back (
    input  logic                clk,
    input  logic                rst_n,
    input  rle4sps_pkg::entry_t q_data,
    input  logic                q_empty,
    output logic                q_pop,
    output logic                empty,
    input  logic                pop,
    output logic [7:0]          out_byte,
    output logic                end_of_image
);
    import rle4sps_pkg::*;

    entry_t     cur_reg;
    logic       cur_valid_reg;
    logic [1:0] idx_reg;
    logic [7:0] obyte_reg;
    logic       oeoi_reg;
    logic       ovalid_reg;
    logic       slot_free, emit, last_byte, load;
    logic [7:0] sel_byte;

    assign slot_free = !ovalid_reg || pop;
    assign emit      = slot_free && cur_valid_reg;
    assign last_byte = (idx_reg == cur_reg.cnt - 2'd1);
    assign load      = !cur_valid_reg || (emit && last_byte);
    assign q_pop     = load && !q_empty;

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    sel_byte = cur_reg.b0;
            2'd1:    sel_byte = cur_reg.b1;
            default: sel_byte = cur_reg.b2;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
        if (emit)
        begin
            obyte_reg <= sel_byte;
            oeoi_reg  <= last_byte && cur_reg.eoi;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            ovalid_reg    <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                cur_valid_reg <= !q_empty;
                idx_reg       <= 2'd0;
            end
            else if (emit)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
            if (emit)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (pop)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    assign empty        = !ovalid_reg;
    assign out_byte     = obyte_reg;
    assign end_of_image = oeoi_reg;

endmodule

// ----- design/rle4_stream_pad_stripper_unit.sv -----
// Top level of the RLE4 stream pad stripper.
// Depends on rle4sps_pkg, rle4sps_front, rle4sps_queue and rle4sps_back.
//
// Copies a BMP 4-bit RLE pixel array byte by byte, dropping the pad byte after
// absolute runs with an odd data byte count, and appends a zero byte after the
// end-of-bitmap escape when the image output count is odd; input up to the
// byte flagged last_of_array is then ignored. One input byte is taken per
// cycle while the four-entry queue has room; the back end emits one result
// byte per cycle while its output register is empty or being popped. Each
// entry passes through the queue, the current-entry register and the output
// register, and an escape that expands to three bytes holds the back end until
// all three are out. Results leave through a registered queue-style port.
module rle4_stream_pad_stripper_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       last_of_array,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       end_of_image
);
    import rle4sps_pkg::*;

    logic   accept;
    logic   ent_valid;
    entry_t ent;
    entry_t q_data;
    logic   q_full, q_empty, q_pop;

    assign full   = q_full;
    assign accept = push && !q_full;

    rle4sps_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (data_byte),
        .last_of_array (last_of_array),
        .ent_valid     (ent_valid),
        .ent           (ent)
    );

    rle4sps_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ent_valid),
        .wr_data (ent),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    rle4sps_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_data       (q_data),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .end_of_image (end_of_image)
    );

endmodule

// ----- design/rle4sps_checker.sv -----
// Port-level checks for the RLE4 stream pad stripper.
// Depends on rle4_stream_pad_stripper_unit; bound to it below.
module rle4sps_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] out_byte,
    input logic       end_of_image
);

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(end_of_image)))
        else $error("stalled result changed");

    // The image ends on the end-of-bitmap code or on the fill byte after it.
    a_eoi_value: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && end_of_image) |-> (out_byte == 8'h01 || out_byte == 8'h00))
        else $error("end_of_image on unexpected byte");

    // Nothing waits on the result side when reset is released.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> empty)
        else $error("result pending out of reset");

endmodule

bind rle4_stream_pad_stripper_unit rle4sps_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .end_of_image (end_of_image)
);
